/* hdl/i2cme_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared constants and types for the byte engine, its register block and its
// sequencer.
// ----------------------------------------------------------------------------
package i2cme_pkg;

   // Command codes carried by the operation field.
   localparam logic [2:0] OP_NONE      = 3'd0;
   localparam logic [2:0] OP_START     = 3'd1;
   localparam logic [2:0] OP_WRITE     = 3'd2;
   localparam logic [2:0] OP_READ_ACK  = 3'd3;
   localparam logic [2:0] OP_READ_NACK = 3'd4;
   localparam logic [2:0] OP_STOP      = 3'd5;

   // Register map: one 32-bit word per register.
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam logic REG_PHASE_TICKS    = 1'b0;
   localparam logic REG_ACK_POLL_LIMIT = 1'b1;

   localparam logic [15:0] PHASE_TICKS_RESET    = 16'd100;
   localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd10;

   // Configuration handed from the register block to the sequencer.
   typedef struct packed {
      logic [15:0] phase_ticks;
      logic [7:0]  ack_poll_limit;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic       ack_failed;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } result_type;

endpackage

/* hdl/i2cme_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine register block
// APB-style access to the phase length and acknowledge poll limit.
// ----------------------------------------------------------------------------
module i2cme_csr
   import i2cme_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   logic [15:0] phase_ticks_ff;
   logic [7:0]  ack_poll_limit_ff;
   logic        wr_en;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   // The register is written in the access cycle of a write transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff    <= PHASE_TICKS_RESET;
         ack_poll_limit_ff <= ACK_POLL_LIMIT_RESET;
      end else if (wr_en) begin
         if (reg_sel == REG_PHASE_TICKS) begin
            phase_ticks_ff <= csr_pwdata[15:0];
         end else begin
            ack_poll_limit_ff <= csr_pwdata[7:0];
         end
      end
   end

   // Read data follows the address.
   always_comb begin
      if (reg_sel == REG_ACK_POLL_LIMIT) begin
         csr_prdata = {24'd0, ack_poll_limit_ff};
      end else begin
         csr_prdata = {16'd0, phase_ticks_ff};
      end
   end

   assign cfg.phase_ticks    = phase_ticks_ff;
   assign cfg.ack_poll_limit = ack_poll_limit_ff;

endmodule

/* hdl/i2cme_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine sequencer
// Advances the bus line state machine by one tick per accepted item and
// forms that tick's result.
// ----------------------------------------------------------------------------
module i2cme_core
   import i2cme_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic [2:0] operation,
   input  logic [7:0] tx_byte,
   input  logic       sda_in,
   output result_type result
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'd0,
      ST_STA_A  = 4'd1,
      ST_STA_B  = 4'd2,
      ST_STP_A  = 4'd3,
      ST_STP_B  = 4'd4,
      ST_STP_C  = 4'd5,
      ST_W_LOW  = 4'd6,
      ST_W_HIGH = 4'd7,
      ST_A_LOW  = 4'd8,
      ST_A_POLL = 4'd9,
      ST_A_HOLD = 4'd10,
      ST_R_LOW  = 4'd11,
      ST_R_HIGH = 4'd12,
      ST_K_LOW  = 4'd13,
      ST_K_HIGH = 4'd14
   } engine_state_type;

   typedef struct packed {
      engine_state_type state;
      logic [15:0]      phase_count;
      logic [3:0]       bit_index;
      logic [7:0]       shift_data;
      logic [7:0]       poll_count;
      logic             scl_level;
      logic             sda_level;
      logic [7:0]       read_result;
      logic             ack_error;
      logic             read_ack;
   } core_state_type;

   core_state_type cur_ff;
   core_state_type cur_in;
   logic           done;
   logic [15:0]    span;

   // Entering a phase restarts its timer and applies its line changes.
   function automatic core_state_type enter_phase(core_state_type s,
                                                  engine_state_type st);
      core_state_type r;
      r             = s;
      r.state       = st;
      r.phase_count = 16'd0;
      case (st)
         ST_STA_A:  begin r.sda_level = 1'b1; r.scl_level = 1'b1; end
         ST_STA_B:  r.sda_level = 1'b0;
         ST_STP_A:  begin r.scl_level = 1'b0; r.sda_level = 1'b0; end
         ST_STP_B:  r.scl_level = 1'b1;
         ST_STP_C:  r.sda_level = 1'b1;
         ST_W_LOW:  begin r.scl_level = 1'b0; r.sda_level = s.shift_data[7]; end
         ST_W_HIGH: r.scl_level = 1'b1;
         ST_A_LOW:  begin r.scl_level = 1'b0; r.sda_level = 1'b1; end
         ST_A_POLL: begin r.scl_level = 1'b1; r.poll_count = 8'd0; end
         ST_R_LOW:  begin r.scl_level = 1'b0; r.sda_level = 1'b1; end
         ST_R_HIGH: r.scl_level = 1'b1;
         ST_K_LOW:  begin r.scl_level = 1'b0; r.sda_level = !s.read_ack; end
         ST_K_HIGH: r.scl_level = 1'b1;
         default:   r.state = st;
      endcase
      return r;
   endfunction

   // A zero phase length behaves as one tick.
   assign span = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;

   // Next state for one tick.
   always_comb begin
      cur_in = cur_ff;
      done   = 1'b0;
      if (cur_ff.state == ST_IDLE) begin
         case (operation)
            OP_START: cur_in = enter_phase(cur_in, ST_STA_A);
            OP_WRITE: begin
               cur_in.shift_data = tx_byte;
               cur_in.bit_index  = 4'd0;
               cur_in.ack_error  = 1'b0;
               cur_in            = enter_phase(cur_in, ST_W_LOW);
            end
            OP_READ_ACK, OP_READ_NACK: begin
               cur_in.shift_data = 8'd0;
               cur_in.bit_index  = 4'd0;
               cur_in.read_ack   = (operation == OP_READ_ACK);
               cur_in            = enter_phase(cur_in, ST_R_LOW);
            end
            OP_STOP: cur_in = enter_phase(cur_in, ST_STP_A);
            default: cur_in = cur_ff;
         endcase
      end else if (cur_ff.state == ST_A_POLL) begin
         // Acknowledge poll: one SDA sample per tick with SCL high.
         if (!sda_in) begin
            cur_in = enter_phase(cur_in, ST_A_HOLD);
         end else if (cur_ff.poll_count >= cfg.ack_poll_limit) begin
            cur_in.ack_error = 1'b1;
            cur_in           = enter_phase(cur_in, ST_STP_A);
         end else begin
            cur_in.poll_count = cur_ff.poll_count + 8'd1;
         end
      end else begin
         // Timed phase: act when the phase length is reached.
         cur_in.phase_count = cur_ff.phase_count + 16'd1;
         if (cur_in.phase_count >= span) begin
            case (cur_ff.state)
               ST_STA_A: cur_in = enter_phase(cur_in, ST_STA_B);
               ST_STP_A: cur_in = enter_phase(cur_in, ST_STP_B);
               ST_STP_B: cur_in = enter_phase(cur_in, ST_STP_C);
               ST_W_LOW: cur_in = enter_phase(cur_in, ST_W_HIGH);
               ST_W_HIGH: begin
                  cur_in.shift_data = {cur_ff.shift_data[6:0], 1'b0};
                  cur_in.bit_index  = cur_ff.bit_index + 4'd1;
                  cur_in = enter_phase(cur_in,
                     (cur_in.bit_index < 4'd8) ? ST_W_LOW : ST_A_LOW);
               end
               ST_A_LOW: cur_in = enter_phase(cur_in, ST_A_POLL);
               ST_R_LOW: cur_in = enter_phase(cur_in, ST_R_HIGH);
               ST_R_HIGH: begin
                  cur_in.shift_data = {cur_ff.shift_data[6:0], sda_in};
                  cur_in.bit_index  = cur_ff.bit_index + 4'd1;
                  cur_in = enter_phase(cur_in,
                     (cur_in.bit_index < 4'd8) ? ST_R_LOW : ST_K_LOW);
               end
               ST_K_LOW: cur_in = enter_phase(cur_in, ST_K_HIGH);
               default: begin
                  // The command finishes on this tick.
                  if (cur_ff.state == ST_STA_B) begin
                     cur_in.scl_level = 1'b0;
                  end
                  if (cur_ff.state == ST_K_HIGH) begin
                     cur_in.read_result = cur_ff.shift_data;
                     if (!cur_ff.read_ack) begin
                        cur_in.scl_level = 1'b0;
                     end
                  end
                  cur_in.state       = ST_IDLE;
                  cur_in.phase_count = 16'd0;
                  done               = 1'b1;
               end
            endcase
         end
      end
   end

   // State register, advanced once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.state       <= ST_IDLE;
         cur_ff.phase_count <= 16'd0;
         cur_ff.bit_index   <= 4'd0;
         cur_ff.shift_data  <= 8'd0;
         cur_ff.poll_count  <= 8'd0;
         cur_ff.scl_level   <= 1'b1;
         cur_ff.sda_level   <= 1'b1;
         cur_ff.read_result <= 8'd0;
         cur_ff.ack_error   <= 1'b0;
         cur_ff.read_ack    <= 1'b0;
      end else if (step) begin
         cur_ff <= cur_in;
      end
   end

   // Result of this tick, taken from the updated state.
   assign result.scl_out    = cur_in.scl_level;
   assign result.sda_out    = cur_in.sda_level;
   assign result.busy_res   = (cur_in.state != ST_IDLE);
   assign result.done_res   = done;
   assign result.rx_byte    = cur_in.read_result;
   assign result.ack_failed = cur_in.ack_error;

`ifndef SYNTHESIS
   // The bit counter never runs past one byte.
   assert property (@(posedge clock) disable iff (reset)
      cur_ff.bit_index <= 4'd8)
      else $error("bit counter ran past eight");

   // SCL stays released while the acknowledge is polled.
   assert property (@(posedge clock) disable iff (reset)
      (cur_ff.state == ST_A_POLL) |-> cur_ff.scl_level)
      else $error("SCL low during acknowledge poll");

   // Without an accepted item the sequencer does not move.
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(cur_ff))
      else $error("sequencer moved without an input transfer");

   // A finishing tick leaves the engine idle.
   assert property (@(posedge clock) disable iff (reset)
      (step && done) |=> (cur_ff.state == ST_IDLE))
      else $error("engine busy after done");
`endif

endmodule

/* hdl/i2c_master_byte_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master line sequencer with a streaming tick input, a
// streaming result output and an APB-style register port.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the req channel is one bus tick. It carries a command
//   code in req_tuser (start, write, read with ACK or NACK, stop, or none),
//   the byte to write and the sampled SDA level. A command is taken only when
//   the engine is idle; otherwise it is ignored.
//   For every req transfer exactly one rsp transfer follows, holding the SCL
//   level, the SDA drive, busy, a done pulse, the last read byte and the
//   acknowledge failure flag.
//   Each rsp item is registered and is offered in the cycle after its req
//   transfer. One tick is taken in every cycle; the single output register
//   frees in the cycle the receiver takes its item, so full rate holds
//   while rsp_tready is high. If the receiver stalls, the output register
//   holds its item and req_tready drops until it is taken.
//   Reset idles the engine with both lines released, clears the output
//   register and loads phase_ticks = 100 and ack_poll_limit = 10.
//   Registers: phase_ticks at byte address 0, ack_poll_limit at address 4.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
   import i2cme_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Tick input.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [15:0]               req_tdata,  // [7:0] tx_byte, [8] sda_in
   input  logic [2:0]                req_tuser,  // [2:0] operation
   // Result output.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata,  // [0] scl_out, [1] sda_out,
                                                 // [2] busy_res, [3] done_res,
                                                 // [11:4] rx_byte, [12] ack_failed
   // Register port.
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       step;

   i2cme_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   i2cme_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .operation (req_tuser),
      .tx_byte   (req_tdata[7:0]),
      .sda_in    (req_tdata[8]),
      .result    (result)
   );

   // A tick is taken whenever the output register is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_data_ff};

endmodule

/* sim/i2c_master_byte_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Feeds bus ticks into the engine and checks each line report against an
// in-bench model of the line sequencer. A short command script comes first,
// then random bus transactions under several phase and poll-limit settings,
// with random gaps and stalls on both stream channels in part of the run.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_tb;
   import i2cme_pkg::*;

   // Operation codes with no meaning; the engine treats them as no command.
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   // Cycles without any transfer before the run is declared hung.
   localparam int unsigned STALL_LIMIT = 1000;

   // Sequencer phases of the line engine.
   typedef enum logic [3:0] {
      ENG_IDLE, ENG_START_HI, ENG_START_LO, ENG_STOP_LO, ENG_STOP_SCL,
      ENG_STOP_SDA, ENG_WR_LOW, ENG_WR_HIGH, ENG_ACK_LOW, ENG_ACK_POLL,
      ENG_ACK_HOLD, ENG_RD_LOW, ENG_RD_HIGH, ENG_ACKOUT_LOW, ENG_ACKOUT_HIGH
   } engine_type;

   // One scripted command: what to send, how often SDA reads low while it
   // runs, whether stray commands are thrown in while busy, and an optional
   // hand-written report for the tick on which it finishes.
   typedef struct {
      logic [2:0]  op;
      logic [7:0]  tx;
      int unsigned low_pct;
      bit          noisy;
      bit          typed;
      result_type  want;
   } cmd_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [15:0]               req_tdata = '0;   // [7:0] tx_byte, [8] sda_in
   logic [2:0]                req_tuser = OP_NONE; // [2:0] operation
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [15:0]               rsp_tdata;        // [0] scl_out, [1] sda_out,
                                                // [2] busy_res, [3] done_res,
                                                // [11:4] rx_byte, [12] ack_failed
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0]               csr_pwdata = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   // Line engine model state and its copy of the registers.
   engine_type  m_state = ENG_IDLE;
   logic [15:0] m_count = '0;
   logic [3:0]  m_bits = '0;
   logic [7:0]  m_shift = '0;
   logic [7:0]  m_polls = '0;
   logic        m_scl = 1'b1;
   logic        m_sda = 1'b1;
   logic [7:0]  m_rx = '0;
   logic        m_ackerr = 1'b0;
   logic        m_send_ack = 1'b0;
   logic [15:0] m_phase = PHASE_TICKS_RESET;
   logic [7:0]  m_limit = ACK_POLL_LIMIT_RESET;

   result_type  due_reports[$];
   bit          idling = 1'b0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned errors = 0;
   int unsigned tick_count = 0;
   int unsigned cmd_count = 0;
   int unsigned read_count = 0;
   int unsigned timeout_count = 0;
   cmd_row_type script [17];

   i2c_master_byte_engine uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic result_type bus_levels(bit scl, bit sda, bit busy, bit done,
                                             logic [7:0] rx, bit ack);
      result_type r;
      r.scl_out = scl;
      r.sda_out = sda;
      r.busy_res = busy;
      r.done_res = done;
      r.rx_byte = rx;
      r.ack_failed = ack;
      return r;
   endfunction

   // Entering a phase restarts its tick count and applies its line changes.
   function automatic void enter_phase(engine_type s);
      m_state = s;
      m_count = '0;
      case (s)
         ENG_START_HI: begin
            m_sda = 1'b1;
            m_scl = 1'b1;
         end
         ENG_START_LO: m_sda = 1'b0;
         ENG_STOP_LO: begin
            m_scl = 1'b0;
            m_sda = 1'b0;
         end
         ENG_STOP_SCL: m_scl = 1'b1;
         ENG_STOP_SDA: m_sda = 1'b1;
         ENG_WR_LOW: begin
            m_scl = 1'b0;
            m_sda = m_shift[7];
         end
         ENG_WR_HIGH: m_scl = 1'b1;
         ENG_ACK_LOW: begin
            m_scl = 1'b0;
            m_sda = 1'b1;
         end
         ENG_ACK_POLL: begin
            m_scl = 1'b1;
            m_polls = '0;
         end
         ENG_RD_LOW: begin
            m_scl = 1'b0;
            m_sda = 1'b1;
         end
         ENG_RD_HIGH: m_scl = 1'b1;
         ENG_ACKOUT_LOW: begin
            m_scl = 1'b0;
            m_sda = !m_send_ack;
         end
         ENG_ACKOUT_HIGH: m_scl = 1'b1;
         default: ;
      endcase
   endfunction

   // End of a timed phase. Returns 1 when the command is complete.
   function automatic bit end_phase(logic sda);
      case (m_state)
         ENG_START_HI: begin
            enter_phase(ENG_START_LO);
            return 1'b0;
         end
         ENG_START_LO: m_scl = 1'b0;
         ENG_STOP_LO: begin
            enter_phase(ENG_STOP_SCL);
            return 1'b0;
         end
         ENG_STOP_SCL: begin
            enter_phase(ENG_STOP_SDA);
            return 1'b0;
         end
         ENG_WR_LOW: begin
            enter_phase(ENG_WR_HIGH);
            return 1'b0;
         end
         ENG_WR_HIGH: begin
            m_shift = m_shift << 1;
            m_bits = m_bits + 4'd1;
            enter_phase(m_bits < 4'd8 ? ENG_WR_LOW : ENG_ACK_LOW);
            return 1'b0;
         end
         ENG_ACK_LOW: begin
            enter_phase(ENG_ACK_POLL);
            return 1'b0;
         end
         ENG_RD_LOW: begin
            enter_phase(ENG_RD_HIGH);
            return 1'b0;
         end
         ENG_RD_HIGH: begin
            m_shift = {m_shift[6:0], sda};
            m_bits = m_bits + 4'd1;
            enter_phase(m_bits < 4'd8 ? ENG_RD_LOW : ENG_ACKOUT_LOW);
            return 1'b0;
         end
         ENG_ACKOUT_LOW: begin
            enter_phase(ENG_ACKOUT_HIGH);
            return 1'b0;
         end
         ENG_ACKOUT_HIGH: begin
            m_rx = m_shift;
            if (!m_send_ack) m_scl = 1'b0;
            read_count++;
         end
         default: ;
      endcase
      m_state = ENG_IDLE;
      m_count = '0;
      return 1'b1;
   endfunction

   // Advances the model by one bus tick and returns the line report for it.
   function automatic result_type next_line_report(logic [2:0] op, logic [7:0] tx,
                                                   logic sda);
      logic [16:0] span;
      bit          fin;
      span = (m_phase == 16'd0) ? 17'd1 : {1'b0, m_phase};
      fin = 1'b0;
      if (m_state == ENG_IDLE) begin
         case (op)
            OP_START: enter_phase(ENG_START_HI);
            OP_WRITE: begin
               m_shift = tx;
               m_bits = '0;
               m_ackerr = 1'b0;
               enter_phase(ENG_WR_LOW);
            end
            OP_READ_ACK, OP_READ_NACK: begin
               m_shift = '0;
               m_bits = '0;
               m_send_ack = (op == OP_READ_ACK);
               enter_phase(ENG_RD_LOW);
            end
            OP_STOP: enter_phase(ENG_STOP_LO);
            default: ;
         endcase
         if (m_state != ENG_IDLE) cmd_count++;
      end else if (m_state == ENG_ACK_POLL) begin
         if (!sda) begin
            enter_phase(ENG_ACK_HOLD);
         end else if (m_polls >= m_limit) begin
            m_ackerr = 1'b1;
            timeout_count++;
            enter_phase(ENG_STOP_LO);
         end else begin
            m_polls = m_polls + 8'd1;
         end
      end else begin
         m_count = m_count + 16'd1;
         if ({1'b0, m_count} >= span) fin = end_phase(sda);
      end
      return bus_levels(m_scl, m_sda, m_state != ENG_IDLE, fin, m_rx, m_ackerr);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, seen);
         errors++;
      end
   endfunction

   function automatic logic sda_draw(int unsigned low_pct);
      return ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
   endfunction

   // Chance in percent that SDA reads low on a tick of one command.
   function automatic int unsigned low_chance();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 100;
         default: return $urandom_range(10, 90);
      endcase
   endfunction

   // Sends one tick and records its expected report once it is taken. A typed
   // report replaces the model's on the tick that leaves the engine idle.
   task automatic send_tick(input logic [2:0] op, input logic [7:0] tx, input logic sda,
                            input bit typed, input result_type want);
      result_type guess;
      int unsigned gap;
      if (idling && $urandom_range(0, 15) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, sda, tx};
      do @(posedge clock); while (!req_tready);
      guess = next_line_report(op, tx, sda);
      if (typed && m_state == ENG_IDLE) guess = want;
      due_reports.push_back(guess);
      tick_count++;
   endtask

   // Issues one command and keeps ticking until the engine is idle again.
   task automatic run_command(input logic [2:0] op, input logic [7:0] tx,
                              input int unsigned low_pct, input bit noisy,
                              input bit typed, input result_type want);
      logic [2:0] fill;
      send_tick(op, tx, sda_draw(low_pct), typed, want);
      while (m_state != ENG_IDLE) begin
         fill = noisy ? 3'($urandom_range(0, 7)) : OP_NONE;
         send_tick(fill, 8'($urandom), sda_draw(low_pct), typed, want);
      end
   endtask

   task automatic random_command(input logic [2:0] op);
      run_command(op, 8'($urandom), low_chance(), $urandom_range(0, 3) == 0, 1'b0, '0);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_WIDTH-1:0] addr, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Registers change only with the engine idle and every report received.
   task automatic set_timing(input logic [15:0] phase, input logic [7:0] limit);
      while (m_state != ENG_IDLE) send_tick(OP_NONE, 8'($urandom), 1'($urandom), 1'b0, '0);
      req_tvalid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      write_reg(CSR_ADDR_WIDTH'({REG_PHASE_TICKS, 2'b00}), {16'd0, phase});
      write_reg(CSR_ADDR_WIDTH'({REG_ACK_POLL_LIMIT, 2'b00}), {24'd0, limit});
      m_phase = phase;
      m_limit = limit;
   endtask

   // Mostly well-formed transactions with random content, some stray commands.
   task automatic run_traffic(input int unsigned budget);
      int unsigned stop_at;
      int unsigned n;
      stop_at = tick_count + budget;
      while (tick_count < stop_at) begin
         if ($urandom_range(0, 4) != 0) begin
            random_command(OP_START);
            random_command(OP_WRITE);
            n = $urandom_range(1, 4);
            repeat (n) random_command($urandom_range(0, 1) ? OP_WRITE : OP_READ_ACK);
            random_command($urandom_range(0, 1) ? OP_READ_NACK : OP_WRITE);
            random_command(OP_STOP);
         end else begin
            random_command(3'($urandom_range(0, 7)));
         end
      end
   endtask

   // Receiver side: random stall bursts while idling is enabled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idling && $urandom_range(0, 15) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Each result transfer is compared with the oldest expected report.
   always @(posedge clock) begin : report_check
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[$bits(result_type)-1:0];
         if (due_reports.size() == 0) begin
            $error("result transfer with no expected report waiting");
            errors++;
         end else begin
            want = due_reports.pop_front();
            check_field("scl_out", 8'(want.scl_out), 8'(seen.scl_out));
            check_field("sda_out", 8'(want.sda_out), 8'(seen.sda_out));
            check_field("busy_res", 8'(want.busy_res), 8'(seen.busy_res));
            check_field("done_res", 8'(want.done_res), 8'(seen.done_res));
            check_field("rx_byte", want.rx_byte, seen.rx_byte);
            check_field("ack_failed", 8'(want.ack_failed), 8'(seen.ack_failed));
         end
      end
   end

   // Hang detection: too many cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // Script runs with one-tick phases (zero is taken as one) and a poll
      // limit of zero, so the first high SDA poll fails the acknowledge.
      script = '{
         '{OP_NONE,      8'h00, 0,   1'b0, 1'b1,
           bus_levels(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0)},
         '{OP_UNUSED_6,  8'hFF, 0,   1'b0, 1'b1,
           bus_levels(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0)},
         '{OP_UNUSED_7,  8'h00, 100, 1'b0, 1'b1,
           bus_levels(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0)},
         '{OP_START,     8'h00, 0,   1'b0, 1'b1,
           bus_levels(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0)},
         '{OP_WRITE,     8'hFF, 0,   1'b0, 1'b1,
           bus_levels(1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1)},
         '{OP_READ_ACK,  8'h00, 0,   1'b1, 1'b1,
           bus_levels(1'b1, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b1)},
         '{OP_WRITE,     8'h00, 100, 1'b1, 1'b1,
           bus_levels(1'b1, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0)},
         '{OP_READ_NACK, 8'hFF, 100, 1'b0, 1'b1,
           bus_levels(1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0)},
         '{OP_STOP,      8'h5A, 50,  1'b0, 1'b1,
           bus_levels(1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0)},
         '{OP_WRITE,     8'hA5, 50,  1'b0, 1'b0, '0},
         '{OP_READ_ACK,  8'h00, 50,  1'b1, 1'b0, '0},
         '{OP_WRITE,     8'h5A, 50,  1'b1, 1'b0, '0},
         '{OP_START,     8'hFF, 50,  1'b1, 1'b0, '0},
         '{OP_NONE,      8'hFF, 100, 1'b0, 1'b0, '0},
         '{OP_READ_NACK, 8'h00, 50,  1'b0, 1'b0, '0},
         '{OP_WRITE,     8'h80, 0,   1'b1, 1'b0, '0},
         '{OP_STOP,      8'h01, 50,  1'b0, 1'b0, '0}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_timing(16'd0, 8'd0);
      foreach (script[i]) begin
         run_command(script[i].op, script[i].tx, script[i].low_pct, script[i].noisy,
                     script[i].typed, script[i].want);
      end

      // Random transactions over a spread of timing settings.
      idling <= 1'b1;
      set_timing(16'd1, 8'd2);
      run_traffic(250);
      set_timing(16'd2, 8'd0);
      run_traffic(200);
      idling <= 1'b0;
      set_timing(16'd0, 8'd255);
      run_traffic(150);
      idling <= 1'b1;
      set_timing(16'd3, 8'd7);
      run_traffic(150);
      set_timing(16'($urandom_range(1, 4)), 8'($urandom_range(0, 20)));
      run_traffic(200);

      // A long phase setting: a single start command.
      idling <= 1'b0;
      set_timing(16'd40, 8'd10);
      random_command(OP_START);

      // Last stretch at full rate with no gaps or stalls.
      set_timing(16'd1, 8'd1);
      run_traffic(200);

      req_tvalid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("Ran %0d ticks with %0d commands taken, %0d bytes read, %0d ack timeouts.",
               tick_count, cmd_count, read_count, timeout_count);
      $display("Phase settings 0 to 40 and poll limits 0 to 255 were exercised.");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
